FILE: src/i2cms_pkg.sv
`default_nettype none

package i2cms_pkg;

  // primitive command codes, code 0 means nothing
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_RECV  = 3'd3,
    CMD_ACK   = 3'd4,
    CMD_STOP  = 3'd5,
    CMD_WAIT  = 3'd6
  } cmd_t;

  localparam logic [7:0] DELAY_RESET = 8'd5;
  localparam logic [7:0] BIT_MSB     = 8'h80;
  localparam logic [7:0] BIT_LSB     = 8'h01;
  localparam logic [7:0] CLR_LSB     = 8'hfe;
  localparam logic [3:0] LAST_BIT    = 4'd7;

  // one tick of protocol timing
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } in_beat_t;

  // pin levels and status after the tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       slave_nack;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: src/i2cms_if.sv
`default_nettype none

// input tick channel
interface i2cms_in_if;
  logic                 valid;
  logic                 ready;
  i2cms_pkg::in_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface i2cms_out_if;
  logic                 valid;
  logic                 ready;
  i2cms_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// delay register write channel
interface i2cms_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/i2c_master_bit_sequencer.sv
`default_nettype none

// I2C master bit sequencer. Every input beat is one protocol tick and yields
// exactly one result beat with the SCL level, the SDA drive (1 released),
// busy, a done pulse, the last received byte and the last slave ack bit.
// One beat is taken per clock cycle: the whole tick is evaluated between the
// sequencer state registers and the result register, and a new beat is taken
// whenever the result register is empty or being drained. While idle a tick
// may carry a command (start, send byte, receive byte, send ack, stop, wait);
// commands arriving while busy are ignored. Pauses between pin edges last
// one or two delay units of cfg data ticks each (zero acts as one).
module i2c_master_bit_sequencer (
  input  wire logic    clk,
  input  wire logic    rst_n,
  i2cms_in_if.sink     in_ch,
  i2cms_out_if.source  out_ch,
  i2cms_cfg_if.sink    cfg_ch
);

  logic [7:0]        delay_r;
  i2cms_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [3:0]        phase_r, phase_nxt;
  logic [3:0]        bit_r, bit_nxt;
  logic [8:0]        tick_r, tick_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              sda_in_mode_r, sda_in_mode_nxt;
  logic              nack_r, nack_nxt;
  logic [7:0]        rx_hold_r, rx_hold_nxt;
  logic              done_nxt;

  logic                  out_valid_r;
  i2cms_pkg::out_beat_t  out_data_r, out_data_nxt;

  logic       in_fire;
  logic       adv;
  logic [1:0] units;
  logic [7:0] unit_ticks;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign unit_ticks   = (delay_r == 8'd0) ? 8'd1 : delay_r;

  // delay register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= i2cms_pkg::DELAY_RESET;
    end else if (cfg_ch.valid) begin
      delay_r <= cfg_ch.data;
    end
  end

  // next state of the sequencer for one tick
  always_comb begin
    cmd_nxt         = cmd_r;
    phase_nxt       = phase_r;
    bit_nxt         = bit_r;
    tick_nxt        = tick_r;
    shift_nxt       = shift_r;
    scl_nxt         = scl_r;
    sda_nxt         = sda_r;
    sda_in_mode_nxt = sda_in_mode_r;
    nack_nxt        = nack_r;
    rx_hold_nxt     = rx_hold_r;
    done_nxt        = 1'b0;
    adv             = 1'b0;
    units           = 2'd0;

    // start a command or count down the pause
    if (cmd_r == i2cms_pkg::CMD_NONE) begin
      if (in_ch.data.req_type >= i2cms_pkg::CMD_START &&
          in_ch.data.req_type <= i2cms_pkg::CMD_WAIT) begin
        cmd_nxt   = i2cms_pkg::cmd_t'(in_ch.data.req_type);
        phase_nxt = 4'd0;
        bit_nxt   = 4'd0;
        if (cmd_nxt == i2cms_pkg::CMD_SEND) begin
          shift_nxt = in_ch.data.tx_byte;
        end
        adv = 1'b1;
      end
    end else begin
      if (tick_r != 9'd0) begin
        tick_nxt = tick_r - 9'd1;
      end
      adv = (tick_nxt == 9'd0);
    end

    // actions of the current phase, units is the following pause
    if (adv) begin
      unique case (cmd_nxt)
        i2cms_pkg::CMD_START: begin
          case (phase_nxt)
            4'd0: begin phase_nxt = 4'd1; units = 2'd1; end
            4'd1: begin
              sda_nxt = 1'b1; scl_nxt = 1'b1; phase_nxt = 4'd2; units = 2'd1;
            end
            4'd2: begin sda_nxt = 1'b0; phase_nxt = 4'd3; units = 2'd1; end
            default: scl_nxt = 1'b0;
          endcase
        end
        i2cms_pkg::CMD_SEND: begin
          case (phase_nxt)
            4'd0: begin scl_nxt = 1'b0; phase_nxt = 4'd1; units = 2'd1; end
            4'd1: begin
              sda_nxt   = |(shift_nxt & i2cms_pkg::BIT_MSB);
              shift_nxt = {shift_nxt[6:0], 1'b0};
              phase_nxt = 4'd2;
              units     = 2'd1;
            end
            4'd2: begin
              scl_nxt = 1'b1;
              if (bit_nxt < i2cms_pkg::LAST_BIT) begin
                bit_nxt   = bit_nxt + 4'd1;
                phase_nxt = 4'd0;
              end else begin
                phase_nxt = 4'd3;
              end
              units = 2'd2;
            end
            4'd3: begin scl_nxt = 1'b0; phase_nxt = 4'd4; units = 2'd1; end
            4'd4: begin sda_in_mode_nxt = 1'b1; phase_nxt = 4'd5; units = 2'd1; end
            4'd5: begin scl_nxt = 1'b1; phase_nxt = 4'd6; units = 2'd1; end
            4'd6: begin
              nack_nxt = in_ch.data.sda_in; phase_nxt = 4'd7; units = 2'd1;
            end
            default: begin scl_nxt = 1'b0; sda_in_mode_nxt = 1'b0; end
          endcase
        end
        i2cms_pkg::CMD_RECV: begin
          case (phase_nxt)
            4'd0: begin
              scl_nxt = 1'b0; sda_nxt = 1'b1; sda_in_mode_nxt = 1'b1;
              phase_nxt = 4'd1; units = 2'd2;
            end
            4'd1: begin
              shift_nxt = {shift_nxt[6:0], 1'b0};
              scl_nxt   = 1'b1;
              phase_nxt = 4'd2;
              units     = 2'd1;
            end
            4'd2: begin
              if (in_ch.data.sda_in) begin
                shift_nxt = shift_nxt | i2cms_pkg::BIT_LSB;
              end else begin
                shift_nxt = shift_nxt & i2cms_pkg::CLR_LSB;
              end
              phase_nxt = 4'd3;
              units     = 2'd1;
            end
            4'd3: begin
              scl_nxt = 1'b0;
              if (bit_nxt < i2cms_pkg::LAST_BIT) begin
                bit_nxt   = bit_nxt + 4'd1;
                phase_nxt = 4'd1;
              end else begin
                phase_nxt = 4'd4;
              end
              units = 2'd2;
            end
            default: begin sda_in_mode_nxt = 1'b0; rx_hold_nxt = shift_nxt; end
          endcase
        end
        i2cms_pkg::CMD_ACK: begin
          if (phase_nxt == 4'd0) begin
            sda_nxt = in_ch.data.ack_level; scl_nxt = 1'b1;
            phase_nxt = 4'd1; units = 2'd2;
          end
        end
        i2cms_pkg::CMD_STOP: begin
          case (phase_nxt)
            4'd0: begin scl_nxt = 1'b0; phase_nxt = 4'd1; units = 2'd1; end
            4'd1: begin sda_nxt = 1'b0; phase_nxt = 4'd2; units = 2'd1; end
            4'd2: begin scl_nxt = 1'b1; phase_nxt = 4'd3; units = 2'd1; end
            4'd3: begin sda_nxt = 1'b1; phase_nxt = 4'd4; units = 2'd1; end
            default: ;
          endcase
        end
        i2cms_pkg::CMD_WAIT: begin
          if (phase_nxt == 4'd0) begin
            phase_nxt = 4'd1; units = 2'd1;
          end
        end
        default: ;
      endcase

      // load the pause or finish the command
      if (units == 2'd0) begin
        cmd_nxt   = i2cms_pkg::CMD_NONE;
        phase_nxt = 4'd0;
        bit_nxt   = 4'd0;
        tick_nxt  = 9'd0;
        done_nxt  = 1'b1;
      end else if (units == 2'd2) begin
        tick_nxt = {unit_ticks, 1'b0};
      end else begin
        tick_nxt = {1'b0, unit_ticks};
      end
    end
  end

  // result beat from the state after the tick
  always_comb begin
    out_data_nxt.scl_level   = scl_nxt;
    out_data_nxt.sda_release = sda_in_mode_nxt | sda_nxt;
    out_data_nxt.busy_res    = (cmd_nxt != i2cms_pkg::CMD_NONE);
    out_data_nxt.done_res    = done_nxt;
    out_data_nxt.rx_byte     = rx_hold_nxt;
    out_data_nxt.slave_nack  = nack_nxt;
  end

  // sequencer state, advances once per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r         <= i2cms_pkg::CMD_NONE;
      phase_r       <= 4'd0;
      bit_r         <= 4'd0;
      tick_r        <= 9'd0;
      shift_r       <= 8'd0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      sda_in_mode_r <= 1'b0;
      nack_r        <= 1'b0;
      rx_hold_r     <= 8'd0;
    end else if (in_fire) begin
      cmd_r         <= cmd_nxt;
      phase_r       <= phase_nxt;
      bit_r         <= bit_nxt;
      tick_r        <= tick_nxt;
      shift_r       <= shift_nxt;
      scl_r         <= scl_nxt;
      sda_r         <= sda_nxt;
      sda_in_mode_r <= sda_in_mode_nxt;
      nack_r        <= nack_nxt;
      rx_hold_r     <= rx_hold_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

`default_nettype wire
